@@ rtl/first_fit_block_allocator_defines.svh @@
// assertion macros for the first-fit block allocator
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FFBA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication, checked outside reset
`define FFBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

@@ rtl/ffba_pkg.sv @@
// shared types, constants and header helpers of the block allocator
package ffba_pkg;

  localparam int DEF_ARENA_BYTES  = 4096;
  localparam int DEF_HEADER_BYTES = 4;

  localparam int SIZE_W = 13;
  localparam int HDR_W  = 15;
  localparam int SUM_W  = 15;
  localparam int OFS_W  = 12;
  localparam int STAT_W = 3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 3'd1;
  localparam logic [STAT_W-1:0] ST_TOOBIG  = 3'd2;
  localparam logic [STAT_W-1:0] ST_BOUNDS  = 3'd3;
  localparam logic [STAT_W-1:0] ST_INVALID = 3'd4;
  localparam logic [STAT_W-1:0] ST_FREED   = 3'd5;

  typedef struct packed {
    logic              valid;
    logic              used;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  function automatic hdr_t make_hdr(logic [SIZE_W-1:0] size, logic used);
    hdr_t h;
    h.valid = 1'b1;
    h.used  = used;
    h.size  = size;
    return h;
  endfunction

endpackage

@@ rtl/ffba_if.sv @@
// request and response channel interfaces of the block allocator
interface ffba_req_if;
  import ffba_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [SIZE_W-1:0] request_bytes;
  logic [SIZE_W-1:0] payload_offset;
  modport source (output valid, func, request_bytes, payload_offset, input ready);
  modport sink   (input valid, func, request_bytes, payload_offset, output ready);
endinterface

interface ffba_rsp_if;
  import ffba_pkg::*;
  logic              valid;
  logic              ready;
  logic [OFS_W-1:0]  granted_offset;
  logic [STAT_W-1:0] status;
  modport source (output valid, granted_offset, status, input ready);
  modport sink   (input valid, granted_offset, status, output ready);
endinterface

@@ rtl/ffba_ram.sv @@
// generic simple dual-port ram with registered read
module ffba_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/first_fit_block_allocator.sv @@
// first-fit block allocator: header walk sequencer around the header ram
//
//  channel  dir  payload                                   transaction
//  req      in   func, request_bytes, payload_offset       valid && ready
//  rsp      out  granted_offset, status                    valid && ready
//
// after reset a clearing pass writes every header entry, with req held off
// one transaction in flight; a chain walk visits each header in a read state and then
// an evaluate state, as the ram read is registered
// free adds the next-block check and a walk from offset 0 to find the previous block
// the result sits in an output register, so a new transaction is taken while rsp stalls
module first_fit_block_allocator #(
  parameter int ARENA_BYTES  = ffba_pkg::DEF_ARENA_BYTES,
  parameter int HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES
) (
  input logic      clk,
  input logic      rst,
  ffba_req_if.sink   req,
  ffba_rsp_if.source rsp
);
  import ffba_pkg::*;
  `include "first_fit_block_allocator_defines.svh"

  localparam int ADDR_W = $clog2(ARENA_BYTES);
  localparam logic [SUM_W-1:0] ARENA = SUM_W'(ARENA_BYTES);
  localparam logic [SUM_W-1:0] HDR   = SUM_W'(HEADER_BYTES);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_A_RD, S_A_EV, S_A_WR2, S_F_RD, S_F_EV,
    S_N_RD, S_N_EV, S_P_RD, S_P_EV, S_P_WR2, S_DONE
  } state_t;

  state_t             state;
  logic [ADDR_W-1:0]  clr_addr;
  logic [SUM_W-1:0]   pos;
  logic [ADDR_W-1:0]  cur;
  logic [ADDR_W-1:0]  rest_addr;
  logic [SIZE_W-1:0]  req_sz;
  logic [SIZE_W-1:0]  cur_size;
  logic [OFS_W-1:0]   res_granted;
  logic [STAT_W-1:0]  res_status;
  logic               out_valid;
  logic [OFS_W-1:0]   out_granted;
  logic [STAT_W-1:0]  out_status;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [HDR_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [HDR_W-1:0]   mem_rdata;

  hdr_t               rd_hdr;
  logic [SUM_W-1:0]   rd_size;
  logic [SUM_W-1:0]   pos_end;
  logic [SUM_W-1:0]   cur_ext;
  logic               fits;
  logic               blk_ok;
  logic [SUM_W-1:0]   req_ext;
  logic [SUM_W-1:0]   off_ext;

  ffba_ram #(.WIDTH(HDR_W), .DEPTH(ARENA_BYTES)) u_hdr_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_hdr  = hdr_t'(mem_rdata);
  assign rd_size = SUM_W'(rd_hdr.size);
  assign pos_end = pos + HDR + rd_size;
  assign cur_ext = SUM_W'(cur);
  assign fits    = !rd_hdr.used && (rd_size >= SUM_W'(req_sz) + HDR);
  assign blk_ok  = rd_hdr.valid && (pos_end <= ARENA);
  assign req_ext = SUM_W'(req.request_bytes);
  assign off_ext = SUM_W'(req.payload_offset);

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.granted_offset = out_granted;
  assign rsp.status         = out_status;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = '0;
    mem_raddr = pos[ADDR_W-1:0];
    unique case (state)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = (clr_addr == '0) ? make_hdr(SIZE_W'(ARENA - HDR), 1'b0) : '0;
      end
      S_A_EV: begin
        if (blk_ok && fits) begin
          mem_we    = 1'b1;
          mem_waddr = pos[ADDR_W-1:0];
          mem_wdata = make_hdr(req_sz, 1'b1);
        end
      end
      S_A_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = rest_addr;
        mem_wdata = make_hdr(cur_size, 1'b0);
      end
      S_F_RD: begin
        mem_raddr = cur;
      end
      S_N_EV: begin
        // absorbed next header is cleared
        if (rd_hdr.valid && !rd_hdr.used) begin
          mem_we    = 1'b1;
          mem_waddr = pos[ADDR_W-1:0];
        end
      end
      S_P_RD: begin
        if (pos >= cur_ext) begin
          mem_we    = 1'b1;
          mem_wdata = make_hdr(cur_size, 1'b0);
        end
      end
      S_P_EV: begin
        if (!rd_hdr.valid) begin
          mem_we    = 1'b1;
          mem_wdata = make_hdr(cur_size, 1'b0);
        end else if (pos_end == cur_ext) begin
          mem_we = 1'b1;
          if (!rd_hdr.used) begin
            mem_waddr = pos[ADDR_W-1:0];
            mem_wdata = make_hdr(SIZE_W'(rd_size + SUM_W'(cur_size) + HDR), 1'b0);
          end else begin
            mem_wdata = make_hdr(cur_size, 1'b0);
          end
        end
      end
      S_P_WR2: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(ARENA_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            res_granted <= '0;
            pos         <= '0;
            req_sz      <= req.request_bytes;
            cur         <= ADDR_W'(off_ext - HDR);
            if (req.func == FUNC_ALLOC) begin
              if (req_ext > ARENA - HDR) begin
                res_status <= ST_TOOBIG;
                state      <= S_DONE;
              end else begin
                state <= S_A_RD;
              end
            end else begin
              if (off_ext < HDR || off_ext > ARENA) begin
                res_status <= ST_BOUNDS;
                state      <= S_DONE;
              end else begin
                state <= S_F_RD;
              end
            end
          end
        end
        S_A_RD: begin
          if (pos >= ARENA) begin
            res_status <= ST_NOSPACE;
            state      <= S_DONE;
          end else begin
            state <= S_A_EV;
          end
        end
        S_A_EV: begin
          if (!blk_ok) begin
            res_status <= ST_NOSPACE;
            state      <= S_DONE;
          end else if (fits) begin
            rest_addr   <= ADDR_W'(pos + HDR + SUM_W'(req_sz));
            cur_size    <= SIZE_W'(rd_size - SUM_W'(req_sz) - HDR);
            res_granted <= OFS_W'(pos + HDR);
            state       <= S_A_WR2;
          end else begin
            pos   <= pos_end;
            state <= S_A_RD;
          end
        end
        S_A_WR2: begin
          res_status <= ST_OK;
          state      <= S_DONE;
        end
        S_F_RD: begin
          state <= S_F_EV;
        end
        S_F_EV: begin
          if (!rd_hdr.valid) begin
            res_status <= ST_INVALID;
            state      <= S_DONE;
          end else if (!rd_hdr.used) begin
            res_status <= ST_FREED;
            state      <= S_DONE;
          end else begin
            cur_size <= rd_hdr.size;
            if (cur_ext + HDR + rd_size < ARENA) begin
              pos   <= cur_ext + HDR + rd_size;
              state <= S_N_RD;
            end else begin
              pos   <= '0;
              state <= S_P_RD;
            end
          end
        end
        S_N_RD: begin
          state <= S_N_EV;
        end
        S_N_EV: begin
          if (rd_hdr.valid && !rd_hdr.used) begin
            cur_size <= SIZE_W'(SUM_W'(cur_size) + rd_size + HDR);
          end
          pos   <= '0;
          state <= S_P_RD;
        end
        S_P_RD: begin
          if (pos >= cur_ext) begin
            res_status <= ST_OK;
            state      <= S_DONE;
          end else begin
            state <= S_P_EV;
          end
        end
        S_P_EV: begin
          if (!rd_hdr.valid) begin
            res_status <= ST_OK;
            state      <= S_DONE;
          end else if (pos_end == cur_ext) begin
            res_status <= ST_OK;
            state      <= rd_hdr.used ? S_DONE : S_P_WR2;
          end else begin
            pos   <= pos_end;
            state <= S_P_RD;
          end
        end
        S_P_WR2: begin
          state <= S_DONE;
        end
        S_DONE: begin
          // wait for the output register to drain
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_granted <= res_granted;
            out_status  <= res_status;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FFBA_ASSERT_NOW(a_no_accept_in_clear, clk, rst, state == S_CLR, !req.ready)
  `FFBA_ASSERT_NOW(a_idle_no_write, clk, rst, state == S_IDLE, !mem_we)
  `FFBA_ASSERT_NOW(a_fail_zero_offset, clk, rst, out_valid && out_status != ST_OK, out_granted == '0)
  `FFBA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, req.valid && req.ready, state != S_IDLE)

endmodule
